// ----- src/ccs_pkg.sv -----
// Shared constants, types and width helpers for the cross-covariance channel selector.
package ccs_pkg;

	localparam int SAMPLE_W      = 16;
	localparam int CHAN_W        = 3;
	localparam int COV_W         = 45;
	localparam int LANES_MAX     = 6;
	localparam int MAX_FRAME_DEF = 4096;
	localparam int CHANNELS_DEF  = 6;

	localparam logic [CHAN_W-1:0] ACTIVE_RESET = CHAN_W'(6);
	localparam logic [CHAN_W-1:0] NO_CHANNEL   = '0;

	typedef enum logic [2:0] {
		S_ACC,
		S_DRAIN,
		S_MUL_LO,
		S_MUL_HI,
		S_NUM,
		S_DIV,
		S_MERGE,
		S_DONE
	} state_t;

	typedef struct packed {
		logic take;
		logic add;
		logic clear;
		logic mul_lo;
		logic mul_hi;
		logic div_load;
		logic div_step;
	} ctrl_t;

	function automatic int cnt_width(input int max_frame);
		return $clog2(max_frame + 1);
	endfunction

	// n*Sxy and Sx*Sy both need 2*cnt+2*SAMPLE_W bits; one more for the difference
	function automatic int num_width(input int max_frame);
		return 2 * cnt_width(max_frame) + 2 * SAMPLE_W + 1;
	endfunction

endpackage

// ----- src/cross_covariance_channel_select.sv -----
// Cross-covariance channel selector: accepts one sample beat per cycle within a frame.
// Throughput: one input beat per cycle while a frame accumulates; at frame end input stalls.
// After the frame-end beat the result passes through the drain, two multiply, numerator,
//   bit-serial divide (one quotient bit a cycle) and merge scan (one lane a cycle) states
//   before it is loaded into the output register.
// Reset (arst_n low) clears all sums and the sample count and sets active_channels to 6.
module cross_covariance_channel_select #(
	parameter int MAX_FRAME = ccs_pkg::MAX_FRAME_DEF,
	parameter int CHANNELS  = ccs_pkg::CHANNELS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [ccs_pkg::SAMPLE_W-1:0]  ref_sample,
	input  logic signed [ccs_pkg::SAMPLE_W-1:0]  ch1_sample,
	input  logic signed [ccs_pkg::SAMPLE_W-1:0]  ch2_sample,
	input  logic signed [ccs_pkg::SAMPLE_W-1:0]  ch3_sample,
	input  logic signed [ccs_pkg::SAMPLE_W-1:0]  ch4_sample,
	input  logic signed [ccs_pkg::SAMPLE_W-1:0]  ch5_sample,
	input  logic signed [ccs_pkg::SAMPLE_W-1:0]  ch6_sample,
	input  logic                                 frame_end,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [ccs_pkg::CHAN_W-1:0]           best_channel,
	output logic [ccs_pkg::COV_W-1:0]            best_covariance,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [ccs_pkg::CHAN_W-1:0]           active_channels
);

	localparam int SW        = ccs_pkg::SAMPLE_W;
	localparam int CNT_W     = ccs_pkg::cnt_width(MAX_FRAME);
	localparam int SUM_W     = SW + CNT_W;
	localparam int QW        = ccs_pkg::num_width(MAX_FRAME) - 1;
	localparam int DC_W      = $clog2(QW);

	ccs_pkg::state_t                 state_q, state_d;
	ccs_pkg::ctrl_t                  ctrl;
	logic [CNT_W-1:0]                count_q;
	logic signed [SUM_W-1:0]         ref_sum_q;
	logic signed [SW-1:0]            ref_s1;
	logic                            acc_s1;
	logic [DC_W-1:0]                 div_cnt_q;
	logic [ccs_pkg::CHAN_W-1:0]      active_q;
	logic                            out_valid_q;
	logic [ccs_pkg::CHAN_W-1:0]      best_channel_q;
	logic [ccs_pkg::COV_W-1:0]       best_covariance_q;

	logic                            in_acc;
	logic                            slot_free;
	logic                            merge_start;
	logic                            merge_last;
	logic                            out_load;
	logic [ccs_pkg::CHAN_W-1:0]      search;
	logic [ccs_pkg::CHAN_W-1:0]      merge_chan;
	logic [QW-1:0]                   merge_val;
	logic [ccs_pkg::LANES_MAX-1:0][SW-1:0] ch_samples;
	logic [CHANNELS-1:0][QW-1:0]     quo;

	assign ch_samples = {ch6_sample, ch5_sample, ch4_sample, ch3_sample, ch2_sample, ch1_sample};
	assign in_acc     = in_valid && in_ready;
	assign slot_free  = !out_valid_q || out_ready;
	assign search     = (active_q > ccs_pkg::CHAN_W'(CHANNELS)) ?
		ccs_pkg::CHAN_W'(CHANNELS) : active_q;
	assign cfg_ready  = 1'b1;

	assign out_valid       = out_valid_q;
	assign best_channel    = best_channel_q;
	assign best_covariance = best_covariance_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ccs_pkg::S_ACC:    if (in_acc && frame_end) state_d = ccs_pkg::S_DRAIN;
			ccs_pkg::S_DRAIN:  state_d = ccs_pkg::S_MUL_LO;
			ccs_pkg::S_MUL_LO: state_d = ccs_pkg::S_MUL_HI;
			ccs_pkg::S_MUL_HI: state_d = ccs_pkg::S_NUM;
			ccs_pkg::S_NUM:    state_d = ccs_pkg::S_DIV;
			ccs_pkg::S_DIV:    if (div_cnt_q == '0) state_d = ccs_pkg::S_MERGE;
			ccs_pkg::S_MERGE:  if (merge_last) state_d = ccs_pkg::S_DONE;
			ccs_pkg::S_DONE:   if (slot_free) state_d = ccs_pkg::S_ACC;
			default:           state_d = ccs_pkg::S_ACC;
		endcase
	end

	always_comb begin
		in_ready      = (state_q == ccs_pkg::S_ACC);
		ctrl.take     = in_acc && (count_q < CNT_W'(MAX_FRAME));
		ctrl.add      = acc_s1;
		ctrl.clear    = (state_q == ccs_pkg::S_DONE) && slot_free;
		ctrl.mul_lo   = (state_q == ccs_pkg::S_MUL_LO);
		ctrl.mul_hi   = (state_q == ccs_pkg::S_MUL_HI);
		ctrl.div_load = (state_q == ccs_pkg::S_NUM);
		ctrl.div_step = (state_q == ccs_pkg::S_DIV);
		merge_start   = (state_q == ccs_pkg::S_DIV) && (div_cnt_q == '0);
		out_load      = ctrl.clear;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ccs_pkg::S_ACC;
			acc_s1    <= 1'b0;
			count_q   <= '0;
			ref_sum_q <= '0;
			div_cnt_q <= '0;
			active_q  <= ccs_pkg::ACTIVE_RESET;
		end else begin
			state_q <= state_d;
			acc_s1  <= ctrl.take;
			if (ctrl.clear) begin
				count_q   <= '0;
				ref_sum_q <= '0;
			end else begin
				if (ctrl.take)
					count_q <= count_q + CNT_W'(1);
				if (acc_s1)
					ref_sum_q <= ref_sum_q + SUM_W'(ref_s1);
			end
			if (ctrl.div_load)
				div_cnt_q <= DC_W'(QW - 1);
			else if (ctrl.div_step)
				div_cnt_q <= div_cnt_q - DC_W'(1);
			if (cfg_valid && cfg_ready)
				active_q <= active_channels;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.take)
			ref_s1 <= ref_sample;
	end

	// output register: next frame may accumulate while this beat waits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			best_channel_q    <= merge_chan;
			best_covariance_q <= ccs_pkg::COV_W'(merge_val);
		end
	end

	for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
		ccs_lane #(
			.MAX_FRAME (MAX_FRAME)
		) u_lane (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.ref_sample (ref_sample),
			.sample     ($signed(ch_samples[g])),
			.ref_sum    (ref_sum_q),
			.n          (count_q),
			.quo        (quo[g])
		);
	end

	ccs_merge #(
		.MAX_FRAME (MAX_FRAME),
		.CHANNELS  (CHANNELS)
	) u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (merge_start),
		.search       (search),
		.quo          (quo),
		.last         (merge_last),
		.best_channel (merge_chan),
		.best_val     (merge_val)
	);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_FRAME))
		else $error("sample count beyond frame limit");

	a_no_chan_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (best_channel_q == ccs_pkg::NO_CHANNEL) |-> best_covariance_q == '0)
		else $error("covariance reported without a channel");

	a_acc_window: assert property (@(posedge clk) disable iff (!arst_n)
		acc_s1 |-> (state_q == ccs_pkg::S_ACC || state_q == ccs_pkg::S_DRAIN))
		else $error("accumulation during frame-end computation");

	a_chan_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> best_channel_q <= search)
		else $error("winning channel outside the searched set");

endmodule

// ----- src/ccs_lane.sv -----
// One channel lane: multiply-accumulate, covariance numerator and restoring divider.
module ccs_lane #(
	parameter int MAX_FRAME = ccs_pkg::MAX_FRAME_DEF
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  ccs_pkg::ctrl_t                               ctrl,
	input  logic signed [ccs_pkg::SAMPLE_W-1:0]          ref_sample,
	input  logic signed [ccs_pkg::SAMPLE_W-1:0]          sample,
	input  logic signed [ccs_pkg::SAMPLE_W+ccs_pkg::cnt_width(MAX_FRAME)-1:0] ref_sum,
	input  logic        [ccs_pkg::cnt_width(MAX_FRAME)-1:0] n,
	output logic        [ccs_pkg::num_width(MAX_FRAME)-2:0] quo
);

	localparam int CNT_W  = ccs_pkg::cnt_width(MAX_FRAME);
	localparam int SW     = ccs_pkg::SAMPLE_W;
	localparam int SUM_W  = SW + CNT_W;
	localparam int PROD_W = 2 * SW - 1 + CNT_W;
	localparam int H      = PROD_W / 2;
	localparam int HI_W   = PROD_W - H;
	localparam int NUM_W  = ccs_pkg::num_width(MAX_FRAME);
	localparam int QW     = NUM_W - 1;

	logic signed [SW-1:0]         x_s1;
	logic signed [2*SW-1:0]       prod_s1;
	logic signed [SUM_W-1:0]      chan_sum_q;
	logic signed [PROD_W-1:0]     cross_sum_q;
	logic        [CNT_W+H-1:0]    prodlo_q;
	logic signed [2*SUM_W-1:0]    sxsy_q;
	logic signed [CNT_W+HI_W:0]   prodhi_q;
	logic signed [NUM_W-1:0]      part_q;
	logic        [QW-1:0]         quo_q;
	logic        [CNT_W-1:0]      rem_q;

	logic        [H-1:0]          lo;
	logic signed [HI_W-1:0]       hi;
	logic signed [NUM_W-1:0]      num;
	logic                         num_pos;
	logic        [CNT_W:0]        trial;
	logic        [CNT_W:0]        diff;

	assign lo      = cross_sum_q[H-1:0];
	assign hi      = cross_sum_q[PROD_W-1:H];
	assign num     = (NUM_W'(prodhi_q) <<< H) + part_q;
	assign num_pos = !num[NUM_W-1] && (num != '0);
	assign trial   = {rem_q, quo_q[QW-1]};
	assign diff    = trial - {1'b0, n};
	assign quo     = quo_q;

	always_ff @(posedge clk) begin
		if (ctrl.take) begin
			x_s1    <= sample;
			prod_s1 <= ref_sample * sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_sum_q  <= '0;
			cross_sum_q <= '0;
		end else if (ctrl.clear) begin
			chan_sum_q  <= '0;
			cross_sum_q <= '0;
		end else if (ctrl.add) begin
			chan_sum_q  <= chan_sum_q + SUM_W'(x_s1);
			cross_sum_q <= cross_sum_q + PROD_W'(prod_s1);
		end
	end

	// numerator n*Sxy - Sx*Sy, n*Sxy split into two partial products
	always_ff @(posedge clk) begin
		if (ctrl.mul_lo) begin
			prodlo_q <= {{H{1'b0}}, n} * {{CNT_W{1'b0}}, lo};
			sxsy_q   <= chan_sum_q * ref_sum;
		end
		if (ctrl.mul_hi) begin
			prodhi_q <= $signed({1'b0, n}) * hi;
			part_q   <= $signed({{(NUM_W-CNT_W-H){1'b0}}, prodlo_q}) - NUM_W'(sxsy_q);
		end
	end

	// one quotient bit per cycle; a non-positive numerator divides as zero
	always_ff @(posedge clk) begin
		if (ctrl.div_load) begin
			quo_q <= num_pos ? num[QW-1:0] : '0;
			rem_q <= '0;
		end else if (ctrl.div_step) begin
			if (!diff[CNT_W]) begin
				rem_q <= diff[CNT_W-1:0];
				quo_q <= {quo_q[QW-2:0], 1'b1};
			end else begin
				rem_q <= trial[CNT_W-1:0];
				quo_q <= {quo_q[QW-2:0], 1'b0};
			end
		end
	end

endmodule

// ----- src/ccs_merge.sv -----
// Merging stage: scans the lane quotients for the strictly greatest positive value.
module ccs_merge #(
	parameter int MAX_FRAME = ccs_pkg::MAX_FRAME_DEF,
	parameter int CHANNELS  = ccs_pkg::CHANNELS_DEF
) (
	input  logic                                                    clk,
	input  logic                                                    arst_n,
	input  logic                                                    start,
	input  logic [ccs_pkg::CHAN_W-1:0]                              search,
	input  logic [CHANNELS-1:0][ccs_pkg::num_width(MAX_FRAME)-2:0]  quo,
	output logic                                                    last,
	output logic [ccs_pkg::CHAN_W-1:0]                              best_channel,
	output logic [ccs_pkg::num_width(MAX_FRAME)-2:0]                best_val
);

	localparam int QW    = ccs_pkg::num_width(MAX_FRAME) - 1;
	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	logic                          busy_q;
	logic [IDX_W-1:0]              idx_q;
	logic [ccs_pkg::CHAN_W-1:0]    best_chan_q;
	logic [QW-1:0]                 best_val_q;
	logic                          better;

	assign last         = busy_q && (idx_q == IDX_W'(CHANNELS - 1));
	assign better       = (ccs_pkg::CHAN_W'(idx_q) < search) && (quo[idx_q] > best_val_q);
	assign best_channel = best_chan_q;
	assign best_val     = best_val_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (busy_q) begin
			busy_q <= !last;
			idx_q  <= last ? '0 : idx_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			best_chan_q <= ccs_pkg::NO_CHANNEL;
			best_val_q  <= '0;
		end else if (busy_q && better) begin
			best_chan_q <= ccs_pkg::CHAN_W'(idx_q) + ccs_pkg::CHAN_W'(1);
			best_val_q  <= quo[idx_q];
		end
	end

endmodule

// ----- bench/cross_covariance_channel_select_test.sv -----
// Self-checking bench for the cross-covariance channel selector: frames in, best channel and covariance checked.
module cross_covariance_channel_select_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LANES        = ccs_pkg::LANES_MAX;
	localparam int MAX_FRAME    = ccs_pkg::MAX_FRAME_DEF;
	localparam int SAMPLE_W     = ccs_pkg::SAMPLE_W;
	localparam int CHAN_W       = ccs_pkg::CHAN_W;
	localparam int COV_W        = ccs_pkg::COV_W;
	localparam int SETTLE       = 100;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 70;

	typedef enum int unsigned {MIC_FREE, MIC_FOLLOW, MIC_INVERT, MIC_NOISY, MIC_FIXED} mic_mode_t;
	typedef enum int unsigned {WORDS_ANY, WORDS_EXTREME, WORDS_ZERO} word_style_t;
	typedef mic_mode_t mode_set_t [LANES];

	typedef struct packed {
		logic [SAMPLE_W-1:0]            beam;
		logic [LANES-1:0][SAMPLE_W-1:0] mic;
		logic                           last;
	} sample_beat_t;

	typedef struct packed {
		logic [CHAN_W-1:0] chan;
		logic [COV_W-1:0]  cov;
	} pick_t;

	class covariance_board;
		int unsigned       n_mismatch;
		logic [CHAN_W-1:0] active;
		int unsigned       taken;
		longint            ref_acc;
		longint            chan_acc [LANES];
		longint            cross_acc [LANES];
		pick_t             pending_picks [$];

		function new();
			n_mismatch = 0;
			active = ccs_pkg::ACTIVE_RESET;
			clear_frame();
		endfunction

		function void clear_frame();
			int i;
			taken = 0;
			ref_acc = 0;
			for (i = 0; i < LANES; i++) begin
				chan_acc[i] = 0;
				cross_acc[i] = 0;
			end
		endfunction

		function void note_sample(input sample_beat_t b);
			longint r, x, n, num, cov, top;
			int     i, span;
			pick_t  p;
			if (taken < MAX_FRAME) begin
				r = $signed(b.beam);
				ref_acc += r;
				for (i = 0; i < LANES; i++) begin
					x = $signed(b.mic[i]);
					chan_acc[i] += x;
					cross_acc[i] += r * x;
				end
				taken++;
			end
			if (!b.last)
				return;
			n = taken;
			top = 0;
			p.chan = ccs_pkg::NO_CHANNEL;
			span = (active > LANES) ? LANES : active;
			for (i = 0; i < span; i++) begin
				num = n * cross_acc[i] - ref_acc * chan_acc[i];
				cov = num / n;
				if (cov > top) begin
					top = cov;
					p.chan = CHAN_W'(i + 1);
				end
			end
			p.cov = top[COV_W-1:0];
			pending_picks.push_back(p);
			clear_frame();
		endfunction

		task flag_mismatch(input string what);
			n_mismatch++;
			$display("%0t ns mismatch: %s", $time, what);
		endtask

		task check_pick(input logic [CHAN_W-1:0] chan, input logic [COV_W-1:0] cov);
			pick_t want;
			if (pending_picks.size() == 0) begin
				flag_mismatch($sformatf("unexpected result: channel %0d cov %0d", chan, cov));
				return;
			end
			want = pending_picks.pop_front();
			if (chan !== want.chan)
				flag_mismatch($sformatf("best_channel %0d, want %0d", chan, want.chan));
			if (cov !== want.cov)
				flag_mismatch($sformatf("best_covariance %0d, want %0d", cov, want.cov));
		endtask
	endclass

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic [SAMPLE_W-1:0]      ref_sample = '0;
	logic [SAMPLE_W-1:0]      ch1_sample = '0;
	logic [SAMPLE_W-1:0]      ch2_sample = '0;
	logic [SAMPLE_W-1:0]      ch3_sample = '0;
	logic [SAMPLE_W-1:0]      ch4_sample = '0;
	logic [SAMPLE_W-1:0]      ch5_sample = '0;
	logic [SAMPLE_W-1:0]      ch6_sample = '0;
	logic                     frame_end = 1'b0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic [CHAN_W-1:0]        best_channel;
	logic [COV_W-1:0]         best_covariance;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [CHAN_W-1:0]        active_channels = ccs_pkg::ACTIVE_RESET;

	covariance_board board;
	bit                quiet = 1'b0;
	int unsigned       cycle_count = 0;
	logic [CHAN_W-1:0] phase_active [PHASES] =
		'{3'd3, 3'd6, 3'd2, 3'd7, 3'd5, 3'd4, 3'd1, 3'd6};

	cross_covariance_channel_select u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.ref_sample     (ref_sample),
		.ch1_sample     (ch1_sample),
		.ch2_sample     (ch2_sample),
		.ch3_sample     (ch3_sample),
		.ch4_sample     (ch4_sample),
		.ch5_sample     (ch5_sample),
		.ch6_sample     (ch6_sample),
		.frame_end      (frame_end),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.best_channel   (best_channel),
		.best_covariance(best_covariance),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.active_channels(active_channels)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count == CYCLE_LIMIT);
		$display("end of test: mismatches");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_pick(best_channel, best_covariance);
	end

	// result side back-pressure
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!quiet && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	function automatic logic [SAMPLE_W-1:0] pick_word(input word_style_t style);
		case (style)
			WORDS_ZERO:    return '0;
			WORDS_EXTREME: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
			default: begin
				case ($urandom_range(0, 7))
					0:       return 16'h8000;
					1:       return 16'h7fff;
					2:       return 16'h0000;
					3:       return 16'hffff;
					default: return SAMPLE_W'($urandom);
				endcase
			end
		endcase
	endfunction

	function automatic logic [SAMPLE_W-1:0] mic_word(input mic_mode_t mode,
			input logic [SAMPLE_W-1:0] beam, input logic [SAMPLE_W-1:0] held,
			input word_style_t style);
		case (mode)
			MIC_FOLLOW: return beam;
			MIC_INVERT: return ~beam;
			MIC_NOISY:  return beam + SAMPLE_W'($urandom_range(0, 63)) - SAMPLE_W'(32);
			MIC_FIXED:  return held;
			default:    return pick_word(style);
		endcase
	endfunction

	function automatic mode_set_t random_modes();
		mode_set_t m;
		int        i;
		for (i = 0; i < LANES; i++)
			m[i] = mic_mode_t'($urandom_range(0, 4));
		return m;
	endfunction

	task automatic send_beat(input sample_beat_t b);
		if (!quiet && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		ref_sample <= b.beam;
		ch1_sample <= b.mic[0];
		ch2_sample <= b.mic[1];
		ch3_sample <= b.mic[2];
		ch4_sample <= b.mic[3];
		ch5_sample <= b.mic[4];
		ch6_sample <= b.mic[5];
		frame_end  <= b.last;
		do @(posedge clk); while (!in_ready);
		board.note_sample(b);
	endtask

	task automatic send_frame(input int len, input mode_set_t modes, input word_style_t style);
		logic [SAMPLE_W-1:0] held [LANES];
		sample_beat_t        b;
		int                  i, k;
		for (i = 0; i < LANES; i++)
			held[i] = pick_word(style);
		for (k = 0; k < len; k++) begin
			b.beam = pick_word(style);
			for (i = 0; i < LANES; i++)
				b.mic[i] = mic_word(modes[i], b.beam, held[i], style);
			b.last = (k == len - 1);
			send_beat(b);
		end
	endtask

	// sender holds off until every pick is back and the divider has gone quiet
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.pending_picks.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_active(input logic [CHAN_W-1:0] count);
		cfg_valid       <= 1'b1;
		active_channels <= count;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		board.active = count;
	endtask

	initial begin
		int          ph, sent, len;
		word_style_t style;
		board = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single-sample frame, ties, all-zero frame, channel 6 winning
		send_frame(1, '{default: MIC_FREE}, WORDS_EXTREME);
		send_frame(2, '{MIC_FOLLOW, MIC_INVERT, MIC_FOLLOW, MIC_FIXED, MIC_NOISY, MIC_FREE},
			WORDS_EXTREME);
		send_frame(3, '{default: MIC_FIXED}, WORDS_ZERO);
		send_frame(4, '{MIC_INVERT, MIC_INVERT, MIC_INVERT, MIC_INVERT, MIC_INVERT, MIC_FOLLOW},
			WORDS_ANY);

		wait_drained();
		write_active(3'd0);
		send_frame(3, '{default: MIC_FOLLOW}, WORDS_ANY);

		wait_drained();
		write_active(3'd7);
		send_frame(4, '{MIC_INVERT, MIC_INVERT, MIC_INVERT, MIC_INVERT, MIC_INVERT, MIC_FOLLOW},
			WORDS_EXTREME);

		wait_drained();
		write_active(3'd1);
		send_frame(4, '{MIC_INVERT, MIC_FOLLOW, MIC_FOLLOW, MIC_FOLLOW, MIC_FOLLOW, MIC_FOLLOW},
			WORDS_ANY);

		for (ph = 0; ph < PHASES; ph++) begin
			wait_drained();
			write_active(phase_active[ph]);
			quiet = (ph == PHASES - 1);
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
				style = ($urandom_range(0, 4) == 0) ? WORDS_EXTREME : WORDS_ANY;
				send_frame(len, random_modes(), style);
				sent += len;
				if (!quiet && $urandom_range(0, 9) == 0)
					wait_drained();
			end
		end

		wait_drained();
		if (board.n_mismatch == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// ----- sim.f -----
src/ccs_pkg.sv
src/ccs_lane.sv
src/ccs_merge.sv
src/cross_covariance_channel_select.sv
bench/cross_covariance_channel_select_test.sv
